/* hw/rtl/glyph_bitmap_run_rects_core_defines.svh */
// Assertion macros for the glyph run rasterizer RTL.
`ifndef GLYPH_BITMAP_RUN_RECTS_CORE_DEFINES_SVH
`define GLYPH_BITMAP_RUN_RECTS_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked while reset is released.
`define GBRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gbrr assertion failed");
// Checked at every edge, reset included.
`define GBRR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gbrr assertion failed");
`else
`define GBRR_ASSERT(lbl, clk, rst_n, prop)
`define GBRR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hw/rtl/gbrr_pkg.sv */
`timescale 1ns / 1ps

package gbrr_pkg;

    // Pixels carried by one bitmap byte.
    localparam int PixPerByte = 8;
    localparam int SlotIdxW   = $clog2(PixPerByte);

    // Mask of the first (leftmost) pixel of a byte.
    localparam logic [7:0] TopBit = 8'h80;

    // Depth of the queue between the scanner and the rectangle stage.
    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);

    // Register reset values.
    localparam logic [7:0]  ScaleReset = 8'd1;
    localparam logic [15:0] ColorReset = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SCALE = 1'b0,
        CFG_COLOR = 1'b1
    } t_cfg_idx;

    // One finished run, in unscaled glyph units.
    typedef struct packed {
        logic [7:0] start_col;
        logic [7:0] run_len;
        logic [7:0] row;
    } t_slot;

    // All runs ended by one bitmap byte, plus the glyph placement.
    typedef struct packed {
        logic [PixPerByte-1:0]  emit_mask;
        t_slot [PixPerByte-1:0] slots;
        logic [15:0]            base_x;
        logic [15:0]            base_y;
        logic [7:0]             off_x;
        logic [7:0]             off_y;
    } t_entry;

endpackage

/* hw/rtl/gbrr_front.sv */
`timescale 1ns / 1ps

module gbrr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_glyph_start,
    input  logic [15:0]     i_origin_x,
    input  logic [15:0]     i_origin_y,
    input  logic [7:0]      i_glyph_width,
    input  logic [7:0]      i_glyph_height,
    input  logic [7:0]      i_offset_x,
    input  logic [7:0]      i_offset_y,
    input  logic [7:0]      i_bitmap_byte,
    input  logic [7:0]      i_scale,
    input  logic            i_full,
    output logic            o_push,
    output gbrr_pkg::t_entry o_entry
);
    import gbrr_pkg::*;

    logic        r_active, n_active;
    logic [7:0]  r_column, n_column;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_run, n_run;
    logic [15:0] r_base_x, n_base_x;
    logic [15:0] r_base_y, n_base_y;
    logic [7:0]  r_width, n_width;
    logic [7:0]  r_height, n_height;
    logic [7:0]  r_off_x, n_off_x;
    logic [7:0]  r_off_y, n_off_y;

    logic        accept;
    t_entry      entry;
    logic        s_active;
    logic [7:0]  s_col;
    logic [7:0]  s_row;
    logic [7:0]  s_run;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Walk the eight pixels of the byte and record every run that ends.
    always_comb begin
        entry = '0;
        if (i_glyph_start) begin
            n_base_x = i_origin_x;
            n_base_y = i_origin_y;
            n_width  = i_glyph_width;
            n_height = i_glyph_height;
            n_off_x  = i_offset_x;
            n_off_y  = i_offset_y;
            s_active = (i_glyph_width != 8'd0) && (i_glyph_height != 8'd0);
            s_col    = 8'd0;
            s_row    = 8'd0;
            s_run    = 8'd0;
        end else begin
            n_base_x = r_base_x;
            n_base_y = r_base_y;
            n_width  = r_width;
            n_height = r_height;
            n_off_x  = r_off_x;
            n_off_y  = r_off_y;
            s_active = r_active;
            s_col    = r_column;
            s_row    = r_row;
            s_run    = r_run;
        end

        for (int i = 0; i < PixPerByte; i++) begin
            if (s_active) begin
                if ((i_bitmap_byte & (TopBit >> i)) != 8'd0) begin
                    s_run = s_run + 8'd1;
                end else if (s_run != 8'd0) begin
                    // A clear pixel closes the open run.
                    entry.emit_mask[i]       = 1'b1;
                    entry.slots[i].start_col = s_col - s_run;
                    entry.slots[i].run_len   = s_run;
                    entry.slots[i].row       = s_row;
                    s_run                    = 8'd0;
                end
                s_col = s_col + 8'd1;
                if (s_col == n_width) begin
                    // The end of a row closes the open run as well.
                    if (s_run != 8'd0) begin
                        entry.emit_mask[i]       = 1'b1;
                        entry.slots[i].start_col = s_col - s_run;
                        entry.slots[i].run_len   = s_run;
                        entry.slots[i].row       = s_row;
                        s_run                    = 8'd0;
                    end
                    s_col = 8'd0;
                    s_row = s_row + 8'd1;
                    if (s_row == n_height) begin
                        s_active = 1'b0;
                    end
                end
            end
        end

        // A zero scale tracks the pixels but draws nothing.
        if (i_scale == 8'd0) begin
            entry.emit_mask = '0;
        end
        entry.base_x = n_base_x;
        entry.base_y = n_base_y;
        entry.off_x  = n_off_x;
        entry.off_y  = n_off_y;

        n_active = s_active;
        n_column = s_col;
        n_row    = s_row;
        n_run    = s_run;
    end

    assign o_push  = accept && (entry.emit_mask != '0);
    assign o_entry = entry;

    // Scan state advances with every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_column <= 8'd0;
            r_row    <= 8'd0;
            r_run    <= 8'd0;
            r_base_x <= 16'd0;
            r_base_y <= 16'd0;
            r_width  <= 8'd0;
            r_height <= 8'd0;
            r_off_x  <= 8'd0;
            r_off_y  <= 8'd0;
        end else if (accept) begin
            r_active <= n_active;
            r_column <= n_column;
            r_row    <= n_row;
            r_run    <= n_run;
            r_base_x <= n_base_x;
            r_base_y <= n_base_y;
            r_width  <= n_width;
            r_height <= n_height;
            r_off_x  <= n_off_x;
            r_off_y  <= n_off_y;
        end
    end

endmodule

/* hw/rtl/gbrr_fifo.sv */
`timescale 1ns / 1ps

module gbrr_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gbrr_pkg::t_entry i_entry,
    input  logic             i_pop,
    output gbrr_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);
    import gbrr_pkg::*;

    t_entry              r_mem [FifoDepth];
    logic [FifoPtrW-1:0] r_wr_ptr;
    logic [FifoPtrW-1:0] r_rd_ptr;
    logic [FifoPtrW:0]   r_count;

    assign o_full  = (r_count == (FifoPtrW+1)'(FifoDepth));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FifoPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FifoPtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (FifoPtrW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (FifoPtrW+1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/gbrr_back.sv */
`timescale 1ns / 1ps

module gbrr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  gbrr_pkg::t_entry i_entry,
    output logic             o_pop,
    input  logic [7:0]       i_scale,
    input  logic [15:0]      i_color,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [15:0]      o_rect_x,
    output logic [15:0]      o_rect_y,
    output logic [15:0]      o_rect_w,
    output logic [7:0]       o_rect_h,
    output logic [15:0]      o_rect_color,
    output logic             o_last
);
    import gbrr_pkg::*;

    t_entry                r_cur;
    logic [PixPerByte-1:0] r_mask, n_mask;

    logic [SlotIdxW-1:0]   sel_idx;
    logic [PixPerByte-1:0] rem_mask;
    t_slot                 sel_slot;
    logic                  take;
    logic                  s1_ready;
    logic                  out_ready;
    logic [15:0]           col_term;
    logic [15:0]           row_term;
    logic [15:0]           mul_x;
    logic [15:0]           mul_y;
    logic [15:0]           mul_w;

    logic                  r_s1_valid;
    logic [15:0]           r_s1_px;
    logic [15:0]           r_s1_py;
    logic [15:0]           r_s1_w;
    logic [15:0]           r_s1_bx;
    logic [15:0]           r_s1_by;
    logic                  r_s1_last;

    logic                  r_out_valid;
    logic [15:0]           r_out_x;
    logic [15:0]           r_out_y;
    logic [15:0]           r_out_w;
    logic [7:0]            r_out_h;
    logic [15:0]           r_out_color;
    logic                  r_out_last;

    // Lowest pending run of the current byte goes first.
    always_comb begin
        sel_idx = '0;
        for (int i = PixPerByte - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel_idx = SlotIdxW'(i);
            end
        end
    end

    assign rem_mask  = r_mask & ~(PixPerByte'(1) << sel_idx);
    assign sel_slot  = r_cur.slots[sel_idx];
    assign out_ready = !r_out_valid || i_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign take      = (r_mask != '0) && s1_ready;
    assign o_pop     = i_valid && ((r_mask == '0) || (take && (rem_mask == '0)));

    always_comb begin
        if (o_pop) begin
            n_mask = i_entry.emit_mask;
        end else if (take) begin
            n_mask = rem_mask;
        end else begin
            n_mask = r_mask;
        end
    end

    // Current byte being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

    // Scaled offsets, truncated to the 16-bit coordinate space.
    assign col_term = {{8{r_cur.off_x[7]}}, r_cur.off_x} + {8'd0, sel_slot.start_col};
    assign row_term = {{8{r_cur.off_y[7]}}, r_cur.off_y} + {8'd0, sel_slot.row};
    assign mul_x    = col_term * i_scale;
    assign mul_y    = row_term * i_scale;
    assign mul_w    = sel_slot.run_len * i_scale;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_px   <= mul_x;
            r_s1_py   <= mul_y;
            r_s1_w    <= mul_w;
            r_s1_bx   <= r_cur.base_x;
            r_s1_by   <= r_cur.base_y;
            r_s1_last <= (rem_mask == '0);
        end
    end

    // Output register with the final additions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_out_x     <= r_s1_bx + r_s1_px;
            r_out_y     <= r_s1_by + r_s1_py;
            r_out_w     <= r_s1_w;
            r_out_h     <= i_scale;
            r_out_color <= i_color;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_rect_x     = r_out_x;
    assign o_rect_y     = r_out_y;
    assign o_rect_w     = r_out_w;
    assign o_rect_h     = r_out_h;
    assign o_rect_color = r_out_color;
    assign o_last       = r_out_last;

endmodule

/* hw/rtl/glyph_bitmap_run_rects_core.sv */
// A run passes the queue, the byte register, the product stage and the output register.
// Throughput: one byte per cycle while the 4-entry queue has room; rectangles leave
// one per cycle while the receiver is ready, each byte's runs before the next byte's.
// Bytes that end no run pass the scanner and never enter the queue.
// Reset (synchronous, active low) clears the glyph scan state, the queue and the
// output stage, and sets scale to 1 and draw color to 0xFFFF.
`timescale 1ns / 1ps
`include "glyph_bitmap_run_rects_core_defines.svh"

module glyph_bitmap_run_rects_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Bitmap byte input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] origin_x, [31:16] origin_y, [39:32] glyph_width, [47:40] glyph_height,
    // [55:48] offset_x, [63:56] offset_y, [71:64] bitmap_byte
    input  logic [71:0] s_axis_tdata,
    // [0] glyph_start
    input  logic        s_axis_tuser,
    // Rectangle output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] rect_x, [31:16] rect_y, [47:32] rect_w, [55:48] rect_h, [71:56] rect_color
    output logic [71:0] m_axis_tdata,
    // last_rect
    output logic        m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    import gbrr_pkg::*;

    logic [7:0]  r_scale;
    logic [15:0] r_color;

    logic        fifo_push;
    logic        fifo_pop;
    logic        fifo_full;
    logic        fifo_empty;
    t_entry      push_entry;
    t_entry      head_entry;

    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [7:0]  rect_h;
    logic [15:0] rect_color;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ScaleReset;
            r_color <= ColorReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE: r_scale <= i_cfg_wdata[7:0];
                CFG_COLOR: r_color <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pixel scanner.
    gbrr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_glyph_start  (s_axis_tuser),
        .i_origin_x     (s_axis_tdata[15:0]),
        .i_origin_y     (s_axis_tdata[31:16]),
        .i_glyph_width  (s_axis_tdata[39:32]),
        .i_glyph_height (s_axis_tdata[47:40]),
        .i_offset_x     (s_axis_tdata[55:48]),
        .i_offset_y     (s_axis_tdata[63:56]),
        .i_bitmap_byte  (s_axis_tdata[71:64]),
        .i_scale        (r_scale),
        .i_full         (fifo_full),
        .o_push         (fifo_push),
        .o_entry        (push_entry)
    );

    // Queue of bytes with finished runs.
    gbrr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_entry (push_entry),
        .i_pop   (fifo_pop),
        .o_entry (head_entry),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // Rectangle generator.
    gbrr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!fifo_empty),
        .i_entry      (head_entry),
        .o_pop        (fifo_pop),
        .i_scale      (r_scale),
        .i_color      (r_color),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_rect_x     (rect_x),
        .o_rect_y     (rect_y),
        .o_rect_w     (rect_w),
        .o_rect_h     (rect_h),
        .o_rect_color (rect_color),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {rect_color, rect_h, rect_w, rect_y, rect_x};

    // The scanner never writes a full queue.
    `GBRR_ASSERT(a_no_overflow, i_clk, i_rst_n, fifo_push |-> !fifo_full)
    // The rectangle stage never reads an empty queue.
    `GBRR_ASSERT(a_no_underflow, i_clk, i_rst_n, fifo_pop |-> !fifo_empty)
    // No rectangle is offered in the cycle after reset.
    `GBRR_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

/* tb/sv/glyph_bitmap_run_rects_core_test.sv */
`timescale 1ns / 1ps

module glyph_bitmap_run_rects_core_test;
    import gbrr_pkg::*;

    // One bitmap byte as it travels on the input stream.
    typedef struct packed {
        logic        start;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  off_x;
        logic [7:0]  off_y;
        logic [7:0]  bits;
    } t_glyph_byte;

    // One filled rectangle as the block should emit it.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [7:0]  h;
        logic [15:0] color;
        logic        last;
    } t_rect;

    // Tracks the glyph scan and holds the rectangles still owed by the block.
    class t_rect_scoreboard;
        logic [7:0]  scale;
        logic [15:0] color;
        logic        active;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  run_len;
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [7:0]  box_w;
        logic [7:0]  box_h;
        logic [7:0]  box_off_x;
        logic [7:0]  box_off_y;
        t_rect       rect_q[$];
        int unsigned errors;

        function new();
            scale     = ScaleReset;
            color     = ColorReset;
            active    = 1'b0;
            column    = '0;
            row       = '0;
            run_len   = '0;
            base_x    = '0;
            base_y    = '0;
            box_w     = '0;
            box_h     = '0;
            box_off_x = '0;
            box_off_y = '0;
            errors    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] value);
            if (idx == CFG_SCALE) begin
                scale = value[7:0];
            end else begin
                color = value;
            end
        endfunction

        function int unsigned pending();
            return rect_q.size();
        endfunction

        // Close the open run and queue its rectangle unless scale is zero.
        function void close_run();
            logic [31:0] start_col;
            logic [31:0] ext_x;
            logic [31:0] ext_y;
            logic [31:0] x_full;
            logic [31:0] y_full;
            logic [31:0] w_full;
            t_rect       r;
            start_col = {24'b0, column - run_len};
            ext_x     = {{24{box_off_x[7]}}, box_off_x};
            ext_y     = {{24{box_off_y[7]}}, box_off_y};
            x_full    = {16'b0, base_x} + (ext_x + start_col) * {24'b0, scale};
            y_full    = {16'b0, base_y} + (ext_y + {24'b0, row}) * {24'b0, scale};
            w_full    = {24'b0, run_len} * {24'b0, scale};
            if (scale != 0) begin
                r.x     = x_full[15:0];
                r.y     = y_full[15:0];
                r.w     = w_full[15:0];
                r.h     = scale;
                r.color = color;
                r.last  = 1'b0;
                rect_q.push_back(r);
            end
            run_len = '0;
        endfunction

        // Advance the scan over one accepted byte and queue the runs it ends.
        function void note_byte(t_glyph_byte b);
            logic [7:0]  mask;
            int unsigned first_new;
            mask      = TopBit;
            first_new = rect_q.size();
            if (b.start) begin
                base_x    = b.origin_x;
                base_y    = b.origin_y;
                box_w     = b.width;
                box_h     = b.height;
                box_off_x = b.off_x;
                box_off_y = b.off_y;
                column    = '0;
                row       = '0;
                run_len   = '0;
                active    = (b.width != 0) && (b.height != 0);
            end
            while (active && mask != 0) begin
                if ((b.bits & mask) != 0) begin
                    run_len = run_len + 8'd1;
                end else if (run_len != 0) begin
                    close_run();
                end
                mask   = mask >> 1;
                column = column + 8'd1;
                // End of a row closes any open run.
                if (column == box_w) begin
                    if (run_len != 0) begin
                        close_run();
                    end
                    column = '0;
                    row    = row + 8'd1;
                    if (row == box_h) begin
                        active = 1'b0;
                    end
                end
            end
            if (rect_q.size() > first_new) begin
                rect_q[rect_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%h, got 0x%h", field, want, got);
                errors++;
            end
        endfunction

        function void check_rect(logic [71:0] data, logic last);
            t_rect want;
            if (rect_q.size() == 0) begin
                $error("unexpected rectangle: data 0x%h, last %b", data, last);
                errors++;
                return;
            end
            want = rect_q.pop_front();
            compare("rect_x", want.x, data[15:0]);
            compare("rect_y", want.y, data[31:16]);
            compare("rect_w", want.w, data[47:32]);
            compare("rect_h", {8'b0, want.h}, {8'b0, data[55:48]});
            compare("rect_color", want.color, data[71:56]);
            compare("last_rect", {15'b0, want.last}, {15'b0, last});
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [0:0]  i_cfg_idx     = '0;
    logic [15:0] i_cfg_wdata   = '0;

    t_rect_scoreboard sb;
    int unsigned      idle_pct  = 0;
    int unsigned      stall_pct = 0;
    int unsigned      hold_left = 0;

    glyph_bitmap_run_rects_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: a long hold-off when requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every rectangle transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_rect(m_axis_tdata, m_axis_tlast);
        end
    end

    // Offer one byte after a random gap and wait for its transaction.
    // Called and returns at a falling edge; tvalid is left high.
    task automatic send_byte(input logic start, input logic [15:0] ox, input logic [15:0] oy,
                             input logic [7:0] w, input logic [7:0] h,
                             input logic [7:0] offx, input logic [7:0] offy,
                             input logic [7:0] bits);
        t_glyph_byte b;
        b = '{start, ox, oy, w, h, offx, offy, bits};
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bits, offy, offx, h, w, oy, ox};
        s_axis_tuser  <= start;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every owed rectangle is out, then settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    // Write both registers on consecutive cycles; only while the block is idle.
    task automatic write_regs(input logic [7:0] scale_val, input logic [15:0] color_val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SCALE;
        i_cfg_wdata <= {8'b0, scale_val};
        sb.write_reg(CFG_SCALE, {8'b0, scale_val});
        @(negedge i_clk);
        i_cfg_idx   <= CFG_COLOR;
        i_cfg_wdata <= color_val;
        sb.write_reg(CFG_COLOR, color_val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pixel_byte();
        case ($urandom_range(5))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // A glyph with random placement; geometry on later bytes is don't-care.
    task automatic send_glyph(input int unsigned w, input int unsigned h,
                              input int unsigned n_bytes);
        for (int unsigned i = 0; i < n_bytes; i++) begin
            send_byte(i == 0, 16'($urandom), 16'($urandom),
                      (i == 0) ? 8'(w) : 8'($urandom), (i == 0) ? 8'(h) : 8'($urandom),
                      8'($urandom), 8'($urandom), pixel_byte());
        end
    endtask

    // Mostly complete small glyphs, a few long rows, some cut short, some noise.
    task automatic random_glyphs(input int unsigned n_bytes, input int unsigned big_pct);
        int unsigned sent;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned nb;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < big_pct) begin
                w = $urandom_range(200, 255);
                h = 1;
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
            nb = (w * h + 7) / 8;
            if (pick >= 80 && pick < 90 && nb > 1) begin
                nb = $urandom_range(1, nb - 1);
            end
            if (pick >= 90) begin
                // Stray byte, or a glyph with an empty box.
                if ($urandom_range(1) == 0) begin
                    send_byte(1'b0, 16'($urandom), 16'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    send_byte(1'b1, 16'($urandom), 16'($urandom),
                              ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom),
                              8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
                end
            end else begin
                send_glyph(w, h, nb);
                sent += nb;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset configuration.
        // Byte with no glyph in progress is ignored.
        send_byte(1'b0, 16'h1234, 16'h5678, 8'd8, 8'd1, 8'h00, 8'h00, 8'hFF);
        // Full row at the coordinate extremes, wrapping.
        send_byte(1'b1, 16'h7FFF, 16'h8000, 8'd8, 8'd1, 8'h7F, 8'h80, 8'hFF);
        // Runs ended by clear pixels, then by the row end.
        send_byte(1'b1, 16'h0000, 16'h0000, 8'd8, 8'd1, 8'h00, 8'h00, 8'hAA);
        send_byte(1'b1, 16'h0010, 16'h0020, 8'd8, 8'd1, 8'h01, 8'hFF, 8'h55);
        // Empty glyphs: zero width, zero height.
        send_byte(1'b1, 16'h0000, 16'h0000, 8'd0, 8'd5, 8'h00, 8'h00, 8'hFF);
        send_byte(1'b1, 16'h0000, 16'h0000, 8'd3, 8'd0, 8'h00, 8'h00, 8'hFF);
        // Largest box, abandoned by a new glyph; rows continue across bytes.
        send_byte(1'b1, 16'h8000, 16'h7FFF, 8'd255, 8'd255, 8'h80, 8'h7F, 8'hFF);
        send_byte(1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F);
        send_byte(1'b1, 16'h0100, 16'h0200, 8'd5, 8'd3, 8'hFE, 8'h02, 8'hFF);
        send_byte(1'b0, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h00, 8'h00, 8'hFF);
        // Bits after the last pixel are dropped, and the next byte is ignored.
        send_byte(1'b1, 16'hFFF0, 16'h0005, 8'd3, 8'd1, 8'h10, 8'h00, 8'hFF);
        send_byte(1'b0, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h00, 8'h00, 8'hFF);
        // Open run thrown away by a new glyph.
        send_byte(1'b1, 16'h0040, 16'h0040, 8'd16, 8'd2, 8'h00, 8'h00, 8'h0F);
        send_byte(1'b1, 16'h0050, 16'h0050, 8'd2, 8'd1, 8'h03, 8'h04, 8'hC0);
        // One pixel per row.
        send_byte(1'b1, 16'h0100, 16'hFF00, 8'd1, 8'd8, 8'h00, 8'hF0, 8'hA5);

        // Zero scale keeps scanning but draws nothing.
        drain();
        write_regs(8'd0, 16'h0000);
        send_byte(1'b1, 16'h0300, 16'h0400, 8'd4, 8'd4, 8'h05, 8'hFB, 8'hFF);
        // Same glyph resumes at full scale.
        drain();
        write_regs(8'd255, 16'hFFFF);
        send_byte(1'b0, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h00, 8'h00, 8'h9F);
        send_byte(1'b1, 16'hC000, 16'h3FFF, 8'd7, 8'd3, 8'h81, 8'h7E, 8'hEF);
        send_byte(1'b0, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h00, 8'h00, 8'hBD);
        send_byte(1'b0, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'h00, 8'h00, 8'hFF);

        // Random part: no idling, with a pause until everything has drained.
        drain();
        write_regs(8'd255, 16'h0000);
        random_glyphs(10, 3);
        drain();
        random_glyphs(10, 3);

        // Zero scale with an idle sender.
        drain();
        write_regs(8'd0, 16'h1234);
        idle_pct = 73;
        random_glyphs(10, 3);

        // Stalling receiver, starting with a long hold-off that backs up the block.
        drain();
        write_regs(8'd3, 16'($urandom));
        idle_pct  = 0;
        stall_pct = 73;
        hold_left = 300;
        random_glyphs(20, 3);

        // Both sides idling, a random scale.
        drain();
        write_regs(8'($urandom_range(1, 255)), 16'($urandom));
        idle_pct  = 28;
        stall_pct = 28;
        random_glyphs(20, 8);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* glyph_bitmap_run_rects_core.f */
+incdir+hw/rtl
hw/rtl/gbrr_pkg.sv
hw/rtl/gbrr_front.sv
hw/rtl/gbrr_fifo.sv
hw/rtl/gbrr_back.sv
hw/rtl/glyph_bitmap_run_rects_core.sv
tb/sv/glyph_bitmap_run_rects_core_test.sv
